// ----- rtl/core/anl_pkg.sv -----
package anl_pkg;

  localparam int LOG_LAT = 17;
  localparam int EXP_LAT = 17;
  localparam int ISQ_LAT = 10;
  localparam int Q16_ONE = 65536;

  localparam int LOG10_2_Q24 = 5050445;
  localparam logic [25:0] EXP_DEN = 26'd50504450;
  localparam logic [47:0] EXP_HALF = 48'd25252225;
  localparam logic [30:0] EXP_RECIP = 31'((64'd1 << 56) / 64'd50504450);

  localparam logic CFG_WIND_SPEED      = 1'b0;
  localparam logic CFG_SHIPPING_FACTOR = 1'b1;

  typedef logic signed [31:0] db_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] log2_c(input logic [63:0] x);
    logic [63:0] m;
    logic [31:0] fr;
    int n;
    n = 0;
    for (int i = 0; i < 63; i++) begin
      if ((x >> (i + 1)) != 0) n = i + 1;
    end
    if (n >= 30) m = x >> (n - 30);
    else m = x << (30 - n);
    fr = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr = fr | 32'd1;
      end
    end
    return (32'(n) << 16) + fr;
  endfunction

  // 2^(-2^-(i+1)) in Q30
  function automatic logic [30:0] exp_tab(input int i);
    logic [63:0] t;
    t = isqrt_c(64'd1 << 59);
    for (int k = 0; k < i; k++) begin
      t = isqrt_c(t << 30);
    end
    return 31'(t);
  endfunction

endpackage

// ----- rtl/core/anl_delay.sv -----
module anl_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] dl [N];

  always_ff @(posedge clk) begin
    if (en) dl[0] <= d;
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) dl[i] <= dl[i-1];
    end
  end

  assign q = dl[N-1];

endmodule

// ----- rtl/core/anl_isqrt.sv -----
module anl_isqrt import anl_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] w,
  output logic [19:0] root
);

  logic [40:0] v_s [ISQ_LAT];
  logic [40:0] r_s [ISQ_LAT];

  for (genvar j = 0; j < ISQ_LAT; j++) begin : g_st
    logic [40:0] v_i;
    logic [40:0] r_i;
    logic [40:0] va;
    logic [40:0] ra;
    logic [40:0] b;

    if (j == 0) begin : g_first
      assign v_i = {1'b0, w, 24'd0};
      assign r_i = '0;
    end else begin : g_next
      assign v_i = v_s[j-1];
      assign r_i = r_s[j-1];
    end

    // two result bits per stage
    always_comb begin
      va = v_i;
      ra = r_i;
      b  = '0;
      for (int k = 0; k < 2; k++) begin
        b = 41'd1 << (2 * (2 * ISQ_LAT - 1 - 2 * j - k));
        if (va >= ra + b) begin
          va = va - (ra + b);
          ra = (ra >> 1) + b;
        end else begin
          ra = ra >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_s[j] <= va;
        r_s[j] <= ra;
      end
    end
  end

  assign root = r_s[ISQ_LAT-1][19:0];

endmodule

// ----- rtl/core/anl_log2.sv -----
module anl_log2 import anl_pkg::*; #(
  parameter int W = 20,
  localparam int NW = $clog2(W)
) (
  input  logic            clk,
  input  logic            en,
  input  logic [W-1:0]    x,
  output logic [NW+15:0]  l
);

  logic [NW-1:0] n_c;
  logic [30:0]   m_c;

  always_comb begin
    n_c = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) n_c = NW'(i);
    end
  end

  assign m_c = 31'({x, 30'b0} >> n_c);

  logic [30:0]   m_s [LOG_LAT];
  logic [15:0]   f_s [LOG_LAT];
  logic [NW-1:0] n_s [LOG_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      m_s[0] <= m_c;
      f_s[0] <= '0;
      n_s[0] <= n_c;
    end
  end

  // one fraction bit per stage: square, renormalize
  for (genvar j = 1; j < LOG_LAT; j++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = 62'(m_s[j-1]) * 62'(m_s[j-1]);
    assign sh = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m_s[j] <= sh[31] ? sh[31:1] : sh[30:0];
        f_s[j] <= {f_s[j-1][14:0], sh[31]};
        n_s[j] <= n_s[j-1];
      end
    end
  end

  assign l = {n_s[LOG_LAT-1], f_s[LOG_LAT-1]};

endmodule

// ----- rtl/core/anl_exp2.sv -----
module anl_exp2 import anl_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [21:0] t,
  input  logic        zero,
  output logic [30:0] pw
);

  logic [30:0] p_s [EXP_LAT-1];
  logic [21:0] t_s [EXP_LAT-1];
  logic        z_s [EXP_LAT-1];

  for (genvar j = 0; j < EXP_LAT - 1; j++) begin : g_st
    localparam logic [30:0] TAB_J = exp_tab(j);
    logic [30:0] p_i;
    logic [21:0] t_i;
    logic        z_i;
    logic [61:0] prod;
    logic [61:0] rnd;

    if (j == 0) begin : g_first
      assign p_i = 31'h4000_0000;
      assign t_i = t;
      assign z_i = zero;
    end else begin : g_next
      assign p_i = p_s[j-1];
      assign t_i = t_s[j-1];
      assign z_i = z_s[j-1];
    end

    assign prod = 62'(p_i) * 62'(TAB_J);
    assign rnd  = prod + (62'd1 << 29);

    always_ff @(posedge clk) begin
      if (en) begin
        p_s[j] <= t_i[15-j] ? 31'(rnd >> 30) : p_i;
        t_s[j] <= t_i;
        z_s[j] <= z_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_s[EXP_LAT-2] || t_s[EXP_LAT-2][21:16] >= 6'd31) pw <= '0;
      else pw <= p_s[EXP_LAT-2] >> t_s[EXP_LAT-2][21:16];
    end
  end

endmodule

// ----- rtl/core/ambient_noise_spectrum_level.sv -----
// Ambient underwater noise level after the four-term Wenz model: each item
// is a frequency in kHz (unsigned, FREQ_FRAC_BITS fraction bits, zero is
// taken as one LSB) and each result is the spectral level in dB re 1 uPa/Hz
// (signed, DB_FRAC_BITS fraction bits, saturated to 16 bits). Turbulence,
// shipping, wind and thermal terms are combined as a power sum relative to
// the largest term. The block is a 62-stage pipeline: it takes one item per
// clock while the output is not stalled; the depth comes from the input and
// power-sum log2 units (16 squaring stages each) and the exp2 lanes (16
// product stages each). A stall on the output side holds the whole
// pipeline. Registers: 0 wind speed (m/s, Q8), 1 shipping factor (Q8, 0..1).
module ambient_noise_spectrum_level import anl_pkg::*; #(
  parameter int FREQ_FRAC_BITS = 10,
  parameter int DB_FRAC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // freq_khz [19:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // noise_db [15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ST_A   = LOG_LAT + 1;
  localparam int ST_B   = ST_A + 1;
  localparam int ST_T   = ST_B + 1;
  localparam int ST_M   = ST_T + 1;
  localparam int ST_Q   = ST_M + 1;
  localparam int ST_E   = ST_Q + 1;
  localparam int ST_P   = ST_E + EXP_LAT;
  localparam int ST_S   = ST_P + 1;
  localparam int ST_L   = ST_S + LOG_LAT;
  localparam int ST_F   = ST_L + 1;
  localparam int ST_R   = ST_F + 1;
  localparam int ST_OUT = ST_R + 1;

  localparam db_t FBQ  = db_t'(FREQ_FRAC_BITS * Q16_ONE);
  localparam db_t L100 = db_t'(log2_c(64'd100));
  localparam db_t L5   = db_t'(log2_c(64'd5));
  localparam db_t CK30 = db_t'(30 * LOG10_2_Q24);
  localparam db_t CK26 = db_t'(26 * LOG10_2_Q24);
  localparam db_t CK60 = db_t'(60 * LOG10_2_Q24);
  localparam db_t CK20 = db_t'(20 * LOG10_2_Q24);
  localparam db_t CK40 = db_t'(40 * LOG10_2_Q24);
  localparam db_t CK10 = db_t'(10 * LOG10_2_Q24);

  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  logic [15:0] wind_speed;
  logic [8:0]  shipping_factor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_speed      <= 16'd256;
      shipping_factor <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIND_SPEED:      wind_speed <= cfg_data;
        CFG_SHIPPING_FACTOR: shipping_factor <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [ST_OUT:0] v;
  logic            en;

  assign en       = !v[ST_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[ST_OUT-1:0], s_tvalid};
  end

  // input stage
  logic [19:0] f_in;
  logic [19:0] f0;
  logic [26:0] xa0;
  logic [22:0] xb0;
  logic [8:0]  s0;
  logic [15:0] w0;

  assign f_in = (s_tdata[19:0] == '0) ? 20'd1 : s_tdata[19:0];

  always_ff @(posedge clk) begin
    if (en) begin
      f0  <= f_in;
      xa0 <= 27'(f_in) * 27'd100 + (27'd3 << FREQ_FRAC_BITS);
      xb0 <= 23'(f_in) * 23'd5 + (23'd2 << FREQ_FRAC_BITS);
      s0  <= (shipping_factor > 9'd256) ? 9'd256 : shipping_factor;
      w0  <= wind_speed;
    end
  end

  logic [20:0] lf_raw;
  logic [20:0] la_raw;
  logic [20:0] lb_raw;
  logic [19:0] sq10;
  logic [19:0] sq17;
  logic [8:0]  s17;

  anl_log2 #(.W(20)) u_log_f (.clk(clk), .en(en), .x(f0),  .l(lf_raw));
  anl_log2 #(.W(27)) u_log_a (.clk(clk), .en(en), .x(xa0), .l(la_raw));
  anl_log2 #(.W(23)) u_log_b (.clk(clk), .en(en), .x(xb0), .l(lb_raw));
  anl_isqrt u_isqrt (.clk(clk), .en(en), .w(w0), .root(sq10));

  anl_delay #(.W(20), .N(LOG_LAT - ISQ_LAT)) u_dly_sq (
    .clk(clk), .en(en), .d(sq10), .q(sq17)
  );
  anl_delay #(.W(9), .N(LOG_LAT)) u_dly_s (
    .clk(clk), .en(en), .d(s0), .q(s17)
  );

  // dB products
  db_t lf;
  db_t la;
  db_t lb;
  assign lf = db_t'({11'b0, lf_raw}) - FBQ;
  assign la = db_t'({11'b0, la_raw}) - L100 - FBQ;
  assign lb = db_t'({11'b0, lb_raw}) - L5 - FBQ;

  logic signed [63:0] p30, p26, p60, p20, p40;
  db_t         sterm18;
  logic [23:0] wterm18;

  always_ff @(posedge clk) begin
    if (en) begin
      p30     <= 64'(lf) * 64'(CK30);
      p26     <= 64'(lf) * 64'(CK26);
      p60     <= 64'(la) * 64'(CK60);
      p20     <= 64'(lf) * 64'(CK20);
      p40     <= 64'(lb) * 64'(CK40);
      sterm18 <= db_t'(20 * (int'({s17, 8'b0}) - 32768));
      wterm18 <= 24'((25'(sq17) * 25'd15 + 25'd1) >> 1);
    end
  end

  db_t d30, d26, d60, d20, d40, sterm19;
  logic [23:0] wterm19;

  always_ff @(posedge clk) begin
    if (en) begin
      d30     <= db_t'(rnd_sh(p30, 24));
      d26     <= db_t'(rnd_sh(p26, 24));
      d60     <= db_t'(rnd_sh(p60, 24));
      d20     <= db_t'(rnd_sh(p20, 24));
      d40     <= db_t'(rnd_sh(p40, 24));
      sterm19 <= sterm18;
      wterm19 <= wterm18;
    end
  end

  db_t term20 [4];

  always_ff @(posedge clk) begin
    if (en) begin
      term20[0] <= db_t'(17 * Q16_ONE) - d30;
      term20[1] <= db_t'(40 * Q16_ONE) + sterm19 + d26 - d60;
      term20[2] <= db_t'(50 * Q16_ONE) + db_t'({8'b0, wterm19}) + d20 - d40;
      term20[3] <= db_t'(-15 * Q16_ONE) + d20;
    end
  end

  db_t m01, m23, mx21;
  db_t term21 [4];
  assign m01 = (term20[1] > term20[0]) ? term20[1] : term20[0];
  assign m23 = (term20[3] > term20[2]) ? term20[3] : term20[2];

  always_ff @(posedge clk) begin
    if (en) begin
      mx21   <= (m23 > m01) ? m23 : m01;
      term21 <= term20;
    end
  end

  // per-term exponent t = round(d / (10 log10 2)), then 2^-t
  logic [21:0] q22  [4];
  logic [22:0] dn22 [4];
  logic        big22 [4];
  logic [21:0] t23  [4];
  logic        big23 [4];
  logic [30:0] pw40 [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic signed [32:0] dd;
    logic [53:0] qp;
    logic [22:0] qp1;
    logic [48:0] chk;
    logic [47:0] nn;

    assign dd  = {mx21[31], mx21} - {term21[i][31], term21[i]};
    assign qp  = 54'(dd[22:0]) * 54'(EXP_RECIP) + (54'd1 << 31);
    assign qp1 = 23'(q22[i]) + 23'd1;
    assign chk = 49'(qp1) * 49'(EXP_DEN);
    assign nn  = {1'b0, dn22[i], 24'd0} + EXP_HALF;

    always_ff @(posedge clk) begin
      if (en) begin
        q22[i]   <= qp[53:32];
        dn22[i]  <= dd[22:0];
        big22[i] <= dd[32:23] != '0;
        t23[i]   <= (chk <= 49'(nn)) ? qp1[21:0] : q22[i];
        big23[i] <= big22[i];
      end
    end

    anl_exp2 u_exp (
      .clk(clk), .en(en), .t(t23[i]), .zero(big23[i]), .pw(pw40[i])
    );
  end

  logic [32:0] sum41;

  always_ff @(posedge clk) begin
    if (en) sum41 <= 33'(pw40[0]) + 33'(pw40[1]) + 33'(pw40[2]) + 33'(pw40[3]);
  end

  logic [21:0] ls58;
  logic [31:0] mx_dly;

  anl_log2 #(.W(33)) u_log_s (.clk(clk), .en(en), .x(sum41), .l(ls58));

  anl_delay #(.W(32), .N(ST_F - ST_M)) u_dly_mx (
    .clk(clk), .en(en), .d(mx21), .q(mx_dly)
  );

  logic signed [63:0] pf59;
  db_t                res60;
  logic signed [63:0] qv;

  always_ff @(posedge clk) begin
    if (en) begin
      pf59  <= 64'(db_t'({10'b0, ls58}) - db_t'(30 * Q16_ONE)) * 64'(CK10);
      res60 <= db_t'(mx_dly) + db_t'(rnd_sh(pf59, 24));
    end
  end

  assign qv = rnd_sh(64'(res60), 16 - DB_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      if (qv > 64'sd32767) m_tdata <= 16'h7fff;
      else if (qv < -64'sd32768) m_tdata <= 16'h8000;
      else m_tdata <= qv[15:0];
    end
  end

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    v[ST_S] |-> (sum41 >= 33'h0_4000_0000 && sum41 <= 33'h1_0000_0000))
    else $error("power sum out of range");

  a_max_lane: assert property (@(posedge clk) disable iff (rst)
    v[ST_E] |-> ((t23[0] == '0 && !big23[0]) || (t23[1] == '0 && !big23[1]) ||
                 (t23[2] == '0 && !big23[2]) || (t23[3] == '0 && !big23[3])))
    else $error("no lane holds the largest term");

  a_log_range: assert property (@(posedge clk) disable iff (rst)
    v[ST_L] |-> (ls58 >= 22'(30 * Q16_ONE) && ls58 <= 22'(32 * Q16_ONE)))
    else $error("log2 of power sum out of range");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import anl_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // freq_khz [19:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // noise_db [15:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  ambient_noise_spectrum_level uut (.*);

  localparam int FB = 10;
  localparam int DB_FB = 8;
  localparam longint L10 = 5050445;
  localparam longint ONE = 65536;

  logic [19:0]     freq_q[$];
  logic [15:0]     level_q[$];
  longint unsigned pow_tab[16];
  logic [15:0]     wind_reg;
  logic [8:0]      ship_reg;
  int              idle_pct;
  int              stall_pct;
  int              hold_cycles;
  bit              hold_req;
  int              errors;
  int              n_items;
  int              n_results;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint log2_q16(input longint unsigned x);
    int n;
    longint unsigned m;
    longint fr;
    n = 0;
    fr = 0;
    if (x == 0) return 0;
    while (n < 63 && (x >> (n + 1)) != 0) n++;
    m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return longint'(n) * ONE + fr;
  endfunction

  function automatic longint db_scale(input longint c, input longint l2);
    return round_shift(c * l2 * L10, 24);
  endfunction

  function automatic longint unsigned pow2_neg(input longint unsigned t);
    longint unsigned k, r, p;
    k = t >> 16;
    r = t & 64'hFFFF;
    p = 64'd1 << 30;
    if (k >= 31) return 0;
    for (int i = 1; i <= 16; i++)
      if (((r >> (16 - i)) & 1) != 0)
        p = (p * pow_tab[i - 1] + (64'd1 << 29)) >> 30;
    return p >> k;
  endfunction

  function automatic logic [15:0] noise_level(input logic [19:0] freq);
    longint unsigned f, s, sq, sum, d, t;
    longint lf, la, lb, mx, res, q;
    longint term[4];
    f = (freq == 0) ? 1 : freq;
    s = (ship_reg > 256) ? 256 : ship_reg;
    sq = int_sqrt(longint'(wind_reg) << 24);
    sum = 0;
    lf = log2_q16(f) - FB * ONE;
    la = log2_q16(100 * f + (64'd3 << FB)) - log2_q16(100) - FB * ONE;
    lb = log2_q16(5 * f + (64'd2 << FB)) - log2_q16(5) - FB * ONE;
    term[0] = 17 * ONE - db_scale(30, lf);
    term[1] = 40 * ONE + 20 * (longint'(s) * 256 - 32768) + db_scale(26, lf)
              - db_scale(60, la);
    term[2] = 50 * ONE + longint'((15 * sq + 1) >> 1) + db_scale(20, lf)
              - db_scale(40, lb);
    term[3] = -15 * ONE + db_scale(20, lf);
    mx = term[0];
    for (int i = 1; i < 4; i++) if (term[i] > mx) mx = term[i];
    for (int i = 0; i < 4; i++) begin
      d = mx - term[i];
      t = ((d << 24) + 64'd25252225) / 64'd50504450;
      sum += pow2_neg(t);
    end
    res = mx + round_shift(10 * (log2_q16(sum) - 30 * ONE) * L10, 24);
    q = round_shift(res, 16 - DB_FB);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        level_q.push_back(noise_level(s_tdata[19:0]));
        n_items++;
      end
      if (!s_tvalid || s_tready) begin
        if (freq_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, freq_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && hold_cycles == 0) hold_cycles <= 400;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // receiver and checker
  always @(posedge clk) begin
    logic [15:0] exp_level;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (level_q.size() == 0) begin
          $error("unexpected item: noise_db actual %0d", $signed(m_tdata));
          errors++;
        end else begin
          exp_level = level_q.pop_front();
          if (m_tdata !== exp_level) begin
            $error("noise_db mismatch: expected %0d actual %0d",
                   $signed(exp_level), $signed(m_tdata));
            errors++;
          end
        end
      end
      m_tready <= (hold_cycles == 0) && !hold_req && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIND_SPEED) wind_reg = val;
    else ship_reg = val[8:0];
  endtask

  task automatic wait_drain();
    while (freq_q.size() > 0 || s_tvalid || level_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_items(input int count);
    logic [19:0] f;
    int w;
    freq_q.push_back(20'd0);
    freq_q.push_back(20'd1);
    freq_q.push_back(20'd2);
    freq_q.push_back(20'd31);
    freq_q.push_back(20'd410);
    freq_q.push_back(20'd1024);
    freq_q.push_back(20'd10240);
    freq_q.push_back(20'h80000);
    freq_q.push_back(20'hFFFFF);
    freq_q.push_back(20'h55555);
    freq_q.push_back(20'hAAAAA);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1) == 0) begin
        f = 20'($urandom);
      end else begin
        w = $urandom_range(20, 1);
        f = 20'($urandom & ((1 << w) - 1));
      end
      freq_q.push_back(f);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIND_SPEED;
    cfg_data = '0;
    wind_reg = 16'd256;
    ship_reg = 9'd0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    hold_req = 1'b0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    pow_tab[0] = int_sqrt(64'd1 << 59);
    for (int i = 1; i < 16; i++) pow_tab[i] = int_sqrt(pow_tab[i - 1] << 30);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    load_items(380);
    wait_drain();

    write_reg(CFG_WIND_SPEED, 16'd0);
    write_reg(CFG_SHIPPING_FACTOR, 16'd0);
    idle_pct = 62;
    load_items(380);
    wait_drain();

    write_reg(CFG_WIND_SPEED, 16'hFFFF);
    write_reg(CFG_SHIPPING_FACTOR, 16'd256);
    idle_pct = 0;
    stall_pct = 62;
    hold_req <= 1'b1;
    load_items(380);
    @(posedge clk);
    hold_req <= 1'b0;
    wait_drain();

    write_reg(CFG_WIND_SPEED, 16'($urandom));
    write_reg(CFG_SHIPPING_FACTOR, 16'd511);
    idle_pct = 17;
    stall_pct = 17;
    load_items(380);
    wait_drain();

    write_reg(CFG_WIND_SPEED, 16'd1280);
    write_reg(CFG_SHIPPING_FACTOR, 16'd128);
    idle_pct = 0;
    stall_pct = 0;
    load_items(380);
    wait_drain();

    if (level_q.size() != 0) begin
      $error("%0d expected items never arrived", level_q.size());
      errors++;
    end
    $display("Covered %0d frequencies and %0d levels over five wind/shipping settings,",
             n_items, n_results);
    $display("including zero and full-scale frequency and out-of-range shipping.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
